FILE: sv/tdo_pkg.sv
// Shared constants and types for the threshold and dilation occupancy block.
`timescale 1ns / 1ps
package tdo_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CFG_W  = 11;
  localparam int POS_W  = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 2);
  localparam int SIZE_W = (POS_W > CFG_W) ? POS_W : CFG_W;
  localparam int OUT_W  = 10;
  localparam int BLUE_W = 8;
  localparam int IDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic [BLUE_W-1:0] THRESHOLD_RESET = BLUE_W'(120);
  localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);

  localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_WIDTH     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_HEIGHT    = IDX_W'(2);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic             mask;
    logic [COL_W-1:0] col;
    logic             out_valid;
    logic             top_ok;
    logic             left_ok;
    logic             right_ok;
    logic [OUT_W-1:0] qr;
    logic [OUT_W-1:0] qc;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic             occupied;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic             last;
  } out_item_t;

endpackage

FILE: sv/threshold_and_dilate_occupancy.sv
// Top level of the binary threshold and 3x3 dilation occupancy block.
//
//   channel  direction  handshake              payload
//   input    in         push / full            command, blue_value
//   result   out        empty / pop            occupied, pixel_row, pixel_column, frame_last
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sustains one pixel per clock when neither side stalls; the line store is read and
// written once per item. A pixel's result rides on the item image_width+1 behind it,
// which passes the queue, the back-end stage and the result buffer to the ports.
// Reset clears control state; the line store needs no clearing pass.
// Either side may stall; the four-entry queue and two-entry result buffer absorb it.
`timescale 1ns / 1ps
module threshold_and_dilate_occupancy import tdo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [BLUE_W-1:0] blue_value,
  output logic              empty,
  input  logic              pop,
  output logic              occupied,
  output logic [OUT_W-1:0]  pixel_row,
  output logic [OUT_W-1:0]  pixel_column,
  output logic              frame_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic     accept;
  q_entry_t front_entry;
  q_entry_t back_entry;
  logic     q_pop;
  logic     q_empty;

  assign accept = push && !full;

  tdo_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .command    (command),
    .blue_value (blue_value),
    .entry      (front_entry)
  );

  tdo_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (back_entry),
    .empty   (q_empty)
  );

  tdo_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (back_entry),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .occupied     (occupied),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .frame_last   (frame_last)
  );

endmodule

FILE: sv/tdo_front.sv
// Front end: configuration registers, stream position and per-pixel classification.
`timescale 1ns / 1ps
module tdo_front import tdo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              accept,
  input  logic              command,
  input  logic [BLUE_W-1:0] blue_value,
  output q_entry_t          entry
);

  logic [BLUE_W-1:0] threshold;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [SIZE_W-1:0] row;
  logic [COL_W-1:0]  col;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] col_ext;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] qr_full;
  logic [SIZE_W-1:0] qc_full;
  logic              col_nz;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = SIZE_W'(1);
    end else if (width_reg > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = SIZE_W'(1);
    end else if (height_reg > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
  end

  always_comb begin
    col_ext = SIZE_W'(col);
    col_inc = col_ext + SIZE_W'(1);
    col_nz  = (col != '0);
    if (col_nz) begin
      qr_full        = row - SIZE_W'(1);
      qc_full        = col_ext - SIZE_W'(1);
      entry.out_valid = (row >= SIZE_W'(1)) && (row <= h_eff);
      entry.top_ok    = (row >= SIZE_W'(2));
      entry.left_ok   = (col >= COL_W'(2));
      entry.right_ok  = 1'b1;
    end else begin
      qr_full        = row - SIZE_W'(2);
      qc_full        = w_eff - SIZE_W'(1);
      entry.out_valid = (row >= SIZE_W'(2)) && (row <= h_eff + SIZE_W'(1));
      entry.top_ok    = (row >= SIZE_W'(3));
      entry.left_ok   = (w_eff >= SIZE_W'(2));
      entry.right_ok  = 1'b0;
    end
    entry.mask = (command == CMD_PIXEL) && (blue_value < threshold) && (row < h_eff);
    entry.col  = col;
    entry.qr   = qr_full[OUT_W-1:0];
    entry.qc   = qc_full[OUT_W-1:0];
    entry.last = (qr_full == h_eff - SIZE_W'(1)) && (qc_full == w_eff - SIZE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      row        <= '0;
      col        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: begin
          threshold <= cfg_data[BLUE_W-1:0];
        end
        REG_WIDTH: begin
          width_reg <= SIZE_W'(cfg_data);
          row       <= '0;
          col       <= '0;
        end
        REG_HEIGHT: begin
          height_reg <= SIZE_W'(cfg_data);
          row        <= '0;
          col        <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (row >= h_eff + SIZE_W'(1)) begin
        row <= '0;
        col <= '0;
      end else if (col_inc >= w_eff) begin
        col <= '0;
        row <= row + SIZE_W'(1);
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    row <= SIZE_W'(MAX_HEIGHT + 1))
    else $error("stream row ran past the flush region");

endmodule

FILE: sv/tdo_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module tdo_queue import tdo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output q_entry_t rd_data,
  output logic     empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("queue read while empty");

endmodule

FILE: sv/tdo_back.sv
// Back end: line store, 3x3 window, dilation and result buffer.
`timescale 1ns / 1ps
module tdo_back import tdo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  q_entry_t         q_entry,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic             occupied,
  output logic [OUT_W-1:0] pixel_row,
  output logic [OUT_W-1:0] pixel_column,
  output logic             frame_last
);

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  logic [1:0]        line_mem [MAX_WIDTH];
  logic [1:0]        mem_q;
  logic              fwd;
  logic [1:0]        fwd_data;

  logic              b_valid;
  q_entry_t          b_entry;
  logic [2:0]        win1;
  logic [2:0]        win2;

  logic [1:0]        rd_word;
  logic [1:0]        wr_word;
  logic [2:0]        cur_vec;
  logic [2:0]        row_mask;
  logic              occ;
  logic              fire;
  logic              out_push;
  logic              out_pop;
  logic              out_space;

  out_item_t         out_slots [OUT_DEPTH];
  out_item_t         out_item;
  logic [OPTR_W-1:0] out_wr_ptr;
  logic [OPTR_W-1:0] out_rd_ptr;
  logic [OCNT_W-1:0] out_count;

  assign rd_word  = fwd ? fwd_data : mem_q;
  assign cur_vec  = {rd_word, b_entry.mask};
  assign wr_word  = {rd_word[0], b_entry.mask};
  assign row_mask = {b_entry.top_ok, 2'b11};

  always_comb begin
    occ = |((win2 & row_mask & {3{b_entry.left_ok}})
          | (win1 & row_mask)
          | (cur_vec & row_mask & {3{b_entry.right_ok}}));
  end

  assign out_pop   = pop && !empty;
  assign out_space = (out_count != OCNT_W'(OUT_DEPTH)) || out_pop;
  assign fire      = b_valid && (!b_entry.out_valid || out_space);
  assign out_push  = fire && b_entry.out_valid;
  assign q_pop     = !q_empty && (!b_valid || fire);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q    <= line_mem[q_entry.col];
      fwd      <= fire && (b_entry.col == q_entry.col);
      fwd_data <= wr_word;
      b_entry  <= q_entry;
    end
    if (fire) begin
      line_mem[b_entry.col] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      win1    <= '0;
      win2    <= '0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (fire) begin
        b_valid <= 1'b0;
      end
      if (fire) begin
        win2 <= win1;
        win1 <= cur_vec;
      end
    end
  end

  always_comb begin
    out_item.occupied = occ;
    out_item.row      = b_entry.qr;
    out_item.col      = b_entry.qc;
    out_item.last     = b_entry.last;
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_slots[out_wr_ptr] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (out_push) begin
        out_wr_ptr <= out_wr_ptr + OPTR_W'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + OPTR_W'(1);
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + OCNT_W'(1);
      end else if (out_pop && !out_push) begin
        out_count <= out_count - OCNT_W'(1);
      end
    end
  end

  assign empty        = (out_count == '0);
  assign occupied     = out_slots[out_rd_ptr].occupied;
  assign pixel_row    = out_slots[out_rd_ptr].row;
  assign pixel_column = out_slots[out_rd_ptr].col;
  assign frame_last   = out_slots[out_rd_ptr].last;

  assert property (@(posedge clk) disable iff (rst)
    out_count <= OCNT_W'(OUT_DEPTH))
    else $error("result buffer count above depth");

  assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_count != OCNT_W'(OUT_DEPTH)) || out_pop)
    else $error("result written into a full buffer");

endmodule
